// ----- hdl/hrsp_pkg.sv -----
package hrsp_pkg;

  // field widths of the result word
  localparam int unsigned BodyLenW = 40;

  // input commands
  localparam logic [1:0] CmdData    = 2'd0;
  localparam logic [1:0] CmdClose   = 2'd1;
  localparam logic [1:0] CmdTimeout = 2'd2;
  localparam logic [1:0] CmdRestart = 2'd3;

  // reported phase
  localparam logic [1:0] PhaseHeaders = 2'd0;
  localparam logic [1:0] PhaseBody    = 2'd1;
  localparam logic [1:0] PhaseDone    = 2'd2;
  localparam logic [1:0] PhaseFailed  = 2'd3;

  // failure reasons
  localparam logic [3:0] ErrNone       = 4'd0;
  localparam logic [3:0] ErrPreamble   = 4'd1;
  localparam logic [3:0] ErrStatusDig  = 4'd2;
  localparam logic [3:0] ErrStatusCode = 4'd3;
  localparam logic [3:0] ErrBadLength  = 4'd4;
  localparam logic [3:0] ErrNoLength   = 4'd5;
  localparam logic [3:0] ErrHdrLong    = 4'd6;
  localparam logic [3:0] ErrClosed     = 4'd7;
  localparam logic [3:0] ErrTimeout    = 4'd8;
  localparam logic [3:0] ErrLenOvf     = 4'd9;

  // characters and limits
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChCaseOfs = 8'h20;

  localparam logic [3:0] PreambleLen = 4'd9;
  localparam logic [3:0] NameLen     = 4'd15;

  localparam logic [9:0]  StatusOk    = 10'd200;
  localparam logic [9:0]  StatusMax   = 10'd999;
  localparam logic [11:0] MaxHdrReset = 12'd1023;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic                payload_valid;
    logic [7:0]          payload_byte;
    logic [1:0]          phase;
    logic [3:0]          error_kind;
    logic [9:0]          status_code;
    logic [BodyLenW-1:0] body_length;
    logic                last;
  } out_word_t;

  // "HTTP/1.0 " by position
  function automatic logic [7:0] preamble_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h30;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "content-length:" in lower case by position
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h6C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/http_response_stream_parser.sv -----
// Byte-stream parser for an HTTP/1.0 response: checks the status line, picks the
// Content-Length header (last one wins, name matched without case) and then passes
// exactly that many body bytes, flagging failures in error_kind. One word is taken
// per clock when the output side keeps up, and every input word gives exactly one
// result word, through the input register and then the result register. The rate is
// set by the parser state update, which reads and writes the whole parse state for
// each word. max_header_bytes must be written through the cfg port only while the
// block is idle; the block itself does not enforce this. LENGTH_BITS sets the width
// of the length and body counters, and body_length shows the low 40 bits of the length.
module http_response_stream_parser #(
  parameter int unsigned LENGTH_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  hrsp_pkg::in_word_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hrsp_pkg::out_word_t   out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [11:0]           cfg_data_i
);

  localparam int unsigned LB = LENGTH_BITS;

  typedef enum logic [3:0] {
    StPre,
    StStatus,
    StReason,
    StLine,
    StName,
    StSpaces,
    StDigits,
    StSkip,
    StEndCr,
    StBody,
    StDone,
    StFail
  } parse_e;

  // configuration register
  logic [11:0] max_hdr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hdr_q <= hrsp_pkg::MaxHdrReset;
    end else if (cfg_valid_i) begin
      max_hdr_q <= cfg_data_i;
    end
  end

  // pipeline handshake
  logic                s1_valid_q;
  hrsp_pkg::in_word_t  s1_word_q;
  logic                out_valid_q;
  hrsp_pkg::out_word_t out_word_q;
  logic                s2_ready;
  logic                s2_fire;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s2_fire    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_word_q <= in_word_i;
    end
  end

  // parse state
  parse_e          ph_q, ph_d;
  logic [3:0]      mpos_q, mpos_d;
  logic [9:0]      status_q, status_d;
  logic            dseen_q, dseen_d;
  logic [LB-1:0]   len_q, len_d;
  logic            lpres_q, lpres_d;
  logic [11:0]     hcnt_q, hcnt_d;
  logic [LB-1:0]   bcnt_q, bcnt_d;
  logic [3:0]      fail_q, fail_d;

  // datapath helpers
  logic [7:0]      b;
  logic [7:0]      lc;
  logic            is_digit;
  logic [3:0]      digit;
  logic [13:0]     status_ext;
  logic [13:0]     status_next;
  logic [LB+3:0]   len_ext;
  logic [LB+3:0]   len_prod;
  logic            len_ovf;
  logic            active;
  logic            res_pv;
  logic            res_last;
  logic [1:0]      res_phase;
  logic [LB+39:0]  len_out_ext;

  assign b          = s1_word_q.data_byte;
  assign lc         = (b >= hrsp_pkg::ChUpA && b <= hrsp_pkg::ChUpZ) ?
                      b + hrsp_pkg::ChCaseOfs : b;
  assign is_digit   = (b >= hrsp_pkg::ChZero) && (b <= hrsp_pkg::ChNine);
  assign digit      = 4'(b - hrsp_pkg::ChZero);
  // status * 10 + digit
  assign status_ext  = {4'b0, status_q};
  assign status_next = (status_ext << 3) + (status_ext << 1) + {10'b0, digit};
  // length * 10 + digit, overflow when the top bits are set
  assign len_ext    = {4'b0, len_q};
  assign len_prod   = (len_ext << 3) + (len_ext << 1) + {{LB{1'b0}}, digit};
  assign len_ovf    = len_prod[LB+3:LB] != 4'b0;
  assign active     = (ph_q != StDone) && (ph_q != StFail);

  // next state for one word
  always_comb begin
    ph_d     = ph_q;
    mpos_d   = mpos_q;
    status_d = status_q;
    dseen_d  = dseen_q;
    len_d    = len_q;
    lpres_d  = lpres_q;
    hcnt_d   = hcnt_q;
    bcnt_d   = bcnt_q;
    fail_d   = fail_q;
    res_pv   = 1'b0;
    res_last = 1'b0;

    unique case (s1_word_q.cmd)
      hrsp_pkg::CmdRestart: begin
        ph_d     = StPre;
        mpos_d   = 4'd0;
        status_d = 10'd0;
        dseen_d  = 1'b0;
        len_d    = '0;
        lpres_d  = 1'b0;
        hcnt_d   = 12'd0;
        bcnt_d   = '0;
        fail_d   = hrsp_pkg::ErrNone;
      end
      hrsp_pkg::CmdClose: begin
        if (active) begin
          ph_d   = StFail;
          fail_d = hrsp_pkg::ErrClosed;
        end
      end
      hrsp_pkg::CmdTimeout: begin
        if (active) begin
          ph_d   = StFail;
          fail_d = hrsp_pkg::ErrTimeout;
        end
      end
      default: begin
        if (ph_q == StBody) begin
          // body byte, count wraps at the counter width
          res_pv = 1'b1;
          bcnt_d = bcnt_q + 1'b1;
          if (bcnt_d >= len_q) begin
            ph_d     = StDone;
            res_last = 1'b1;
          end
        end else if (active) begin
          if (hcnt_q >= max_hdr_q) begin
            ph_d   = StFail;
            fail_d = hrsp_pkg::ErrHdrLong;
          end else begin
            hcnt_d = hcnt_q + 1'b1;
            unique case (ph_q)
              StPre: begin
                if (mpos_q < hrsp_pkg::PreambleLen &&
                    b == hrsp_pkg::preamble_char(mpos_q)) begin
                  if (mpos_q == hrsp_pkg::PreambleLen - 4'd1) begin
                    ph_d   = StStatus;
                    mpos_d = 4'd0;
                  end else begin
                    mpos_d = mpos_q + 4'd1;
                  end
                end else begin
                  ph_d   = StFail;
                  fail_d = hrsp_pkg::ErrPreamble;
                end
              end
              StStatus: begin
                if (is_digit) begin
                  status_d = (status_next > {4'b0, hrsp_pkg::StatusMax}) ?
                             hrsp_pkg::StatusMax : status_next[9:0];
                  dseen_d  = 1'b1;
                end else if (!dseen_q || b != hrsp_pkg::ChSpace) begin
                  ph_d   = StFail;
                  fail_d = hrsp_pkg::ErrStatusDig;
                end else if (status_q != hrsp_pkg::StatusOk) begin
                  ph_d   = StFail;
                  fail_d = hrsp_pkg::ErrStatusCode;
                end else begin
                  dseen_d = 1'b0;
                  ph_d    = StReason;
                end
              end
              StReason, StSkip: begin
                if (b == hrsp_pkg::ChLf) begin
                  ph_d = StLine;
                end
              end
              StLine: begin
                if (b == hrsp_pkg::ChCr) begin
                  ph_d = StEndCr;
                end else if (b == hrsp_pkg::ChLf) begin
                  // blank line ends the headers
                  if (!lpres_q) begin
                    ph_d   = StFail;
                    fail_d = hrsp_pkg::ErrNoLength;
                  end else if (len_q == '0) begin
                    ph_d     = StDone;
                    res_last = 1'b1;
                  end else begin
                    ph_d = StBody;
                  end
                end else if (lc == hrsp_pkg::name_char(4'd0)) begin
                  mpos_d = 4'd1;
                  ph_d   = StName;
                end else begin
                  ph_d = StSkip;
                end
              end
              StName: begin
                if (mpos_q < hrsp_pkg::NameLen &&
                    lc == hrsp_pkg::name_char(mpos_q)) begin
                  if (mpos_q == hrsp_pkg::NameLen - 4'd1) begin
                    mpos_d  = 4'd0;
                    len_d   = '0;
                    lpres_d = 1'b0;
                    dseen_d = 1'b0;
                    ph_d    = StSpaces;
                  end else begin
                    mpos_d = mpos_q + 4'd1;
                  end
                end else begin
                  mpos_d = 4'd0;
                  ph_d   = (b == hrsp_pkg::ChLf) ? StLine : StSkip;
                end
              end
              StSpaces, StDigits: begin
                if (ph_q == StSpaces && b == hrsp_pkg::ChSpace) begin
                  ph_d = StSpaces;
                end else if (is_digit) begin
                  if (len_ovf) begin
                    ph_d   = StFail;
                    fail_d = hrsp_pkg::ErrLenOvf;
                  end else begin
                    len_d   = len_prod[LB-1:0];
                    dseen_d = 1'b1;
                    ph_d    = StDigits;
                  end
                end else if (!dseen_q ||
                             (b != hrsp_pkg::ChCr && b != hrsp_pkg::ChLf)) begin
                  ph_d   = StFail;
                  fail_d = hrsp_pkg::ErrBadLength;
                end else begin
                  lpres_d = 1'b1;
                  ph_d    = (b == hrsp_pkg::ChLf) ? StLine : StSkip;
                end
              end
              StEndCr: begin
                // byte after the blank-line CR
                if (!lpres_q) begin
                  ph_d   = StFail;
                  fail_d = hrsp_pkg::ErrNoLength;
                end else if (len_q == '0) begin
                  ph_d     = StDone;
                  res_last = 1'b1;
                end else begin
                  ph_d = StBody;
                end
              end
              default: begin
                ph_d = ph_q;
              end
            endcase
          end
        end
      end
    endcase
  end

  // result word
  always_comb begin
    unique case (ph_d)
      StBody:  res_phase = hrsp_pkg::PhaseBody;
      StDone:  res_phase = hrsp_pkg::PhaseDone;
      StFail:  res_phase = hrsp_pkg::PhaseFailed;
      default: res_phase = hrsp_pkg::PhaseHeaders;
    endcase
  end

  assign len_out_ext = {40'b0, len_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= StPre;
      mpos_q   <= 4'd0;
      status_q <= 10'd0;
      dseen_q  <= 1'b0;
      len_q    <= '0;
      lpres_q  <= 1'b0;
      hcnt_q   <= 12'd0;
      bcnt_q   <= '0;
      fail_q   <= hrsp_pkg::ErrNone;
    end else if (s2_fire) begin
      ph_q     <= ph_d;
      mpos_q   <= mpos_d;
      status_q <= status_d;
      dseen_q  <= dseen_d;
      len_q    <= len_d;
      lpres_q  <= lpres_d;
      hcnt_q   <= hcnt_d;
      bcnt_q   <= bcnt_d;
      fail_q   <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_word_q.payload_valid <= res_pv;
      out_word_q.payload_byte  <= res_pv ? b : 8'd0;
      out_word_q.phase         <= res_phase;
      out_word_q.error_kind    <= fail_d;
      out_word_q.status_code   <= status_d;
      out_word_q.body_length   <= len_out_ext[hrsp_pkg::BodyLenW-1:0];
      out_word_q.last          <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // checks
  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.payload_valid |->
      (out_word_o.phase == hrsp_pkg::PhaseBody ||
       out_word_o.phase == hrsp_pkg::PhaseDone))
    else $error("payload word outside body");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.last |-> out_word_o.phase == hrsp_pkg::PhaseDone)
    else $error("last without completion");

  a_fail_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_word_o.phase == hrsp_pkg::PhaseFailed) ==
       (out_word_o.error_kind != hrsp_pkg::ErrNone)))
    else $error("failure phase and reason disagree");

  a_body_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == StBody |-> len_q != '0)
    else $error("body phase with zero length");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LenBits    = 40;
  localparam logic [63:0] LenMask    = (64'd1 << LenBits) - 64'd1;
  localparam int          HoldCycles = 300;
  localparam int          IdleLimit  = 3000;

  // parser position inside a response
  typedef enum logic [3:0] {
    PsPreamble, PsStatus, PsReason, PsLineStart, PsName, PsSpaces,
    PsDigits, PsSkipLine, PsAfterCr, PsBody, PsDone, PsFailed
  } parse_state_e;

  // running model of the parser and the words it still owes
  class parse_scoreboard;
    hrsp_pkg::out_word_t expected_q[$];
    int           mismatches;
    logic [11:0]  max_hdr;
    parse_state_e st;
    int           pos;
    logic [9:0]   status;
    bit           digit_seen;
    logic [63:0]  len_val;
    bit           len_seen;
    logic [11:0]  hdr_cnt;
    logic [63:0]  body_cnt;
    logic [3:0]   fail_code;
    string        pre_text  = "HTTP/1.0 ";
    string        name_text = "content-length:";

    function new();
      mismatches = 0;
      max_hdr    = hrsp_pkg::MaxHdrReset;
      restart_parse();
    endfunction

    function void restart_parse();
      st         = PsPreamble;
      pos        = 0;
      status     = '0;
      digit_seen = 1'b0;
      len_val    = '0;
      len_seen   = 1'b0;
      hdr_cnt    = '0;
      body_cnt   = '0;
      fail_code  = hrsp_pkg::ErrNone;
    endfunction

    function void set_failure(logic [3:0] k);
      st        = PsFailed;
      fail_code = k;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= hrsp_pkg::ChZero && b <= hrsp_pkg::ChNine;
    endfunction

    // blank line seen: decide body, done or missing length
    function bit end_headers();
      if (!len_seen) begin
        set_failure(hrsp_pkg::ErrNoLength);
        return 1'b0;
      end
      if (len_val == 0) begin
        st = PsDone;
        return 1'b1;
      end
      st = PsBody;
      return 1'b0;
    endfunction

    function void length_char(logic [7:0] b);
      logic [63:0] d;
      if (is_digit(b)) begin
        d = 64'(b - hrsp_pkg::ChZero);
        if (len_val > (LenMask - d) / 10) begin
          set_failure(hrsp_pkg::ErrLenOvf);
          return;
        end
        len_val    = len_val * 10 + d;
        digit_seen = 1'b1;
        st         = PsDigits;
        return;
      end
      if (!digit_seen || (b != hrsp_pkg::ChCr && b != hrsp_pkg::ChLf)) begin
        set_failure(hrsp_pkg::ErrBadLength);
        return;
      end
      len_seen = 1'b1;
      st       = (b == hrsp_pkg::ChLf) ? PsLineStart : PsSkipLine;
    endfunction

    // one counted header byte, returns 1 when the response completes
    function bit take_header_byte(logic [7:0] b);
      logic [7:0] lc;
      int         v;
      lc = (b >= hrsp_pkg::ChUpA && b <= hrsp_pkg::ChUpZ) ? b + hrsp_pkg::ChCaseOfs : b;
      case (st)
        PsPreamble: begin
          if (pos < 9 && b == pre_text[pos]) begin
            pos++;
            if (pos == 9) begin
              st  = PsStatus;
              pos = 0;
            end
          end else begin
            set_failure(hrsp_pkg::ErrPreamble);
          end
        end
        PsStatus: begin
          if (is_digit(b)) begin
            v          = int'(status) * 10 + int'(b - hrsp_pkg::ChZero);
            status     = (v > 999) ? hrsp_pkg::StatusMax : 10'(v);
            digit_seen = 1'b1;
          end else if (!digit_seen || b != hrsp_pkg::ChSpace) begin
            set_failure(hrsp_pkg::ErrStatusDig);
          end else if (status != hrsp_pkg::StatusOk) begin
            set_failure(hrsp_pkg::ErrStatusCode);
          end else begin
            digit_seen = 1'b0;
            st         = PsReason;
          end
        end
        PsReason, PsSkipLine: begin
          if (b == hrsp_pkg::ChLf) st = PsLineStart;
        end
        PsLineStart: begin
          if (b == hrsp_pkg::ChCr) begin
            st = PsAfterCr;
          end else if (b == hrsp_pkg::ChLf) begin
            return end_headers();
          end else if (lc == name_text[0]) begin
            pos = 1;
            st  = PsName;
          end else begin
            st = PsSkipLine;
          end
        end
        PsName: begin
          if (pos < 15 && lc == name_text[pos]) begin
            pos++;
            if (pos == 15) begin
              pos        = 0;
              len_val    = '0;
              len_seen   = 1'b0;
              digit_seen = 1'b0;
              st         = PsSpaces;
            end
          end else begin
            pos = 0;
            st  = (b == hrsp_pkg::ChLf) ? PsLineStart : PsSkipLine;
          end
        end
        PsSpaces: begin
          if (b != hrsp_pkg::ChSpace) length_char(b);
        end
        PsDigits: length_char(b);
        PsAfterCr: return end_headers();
        default: ;
      endcase
      return 1'b0;
    endfunction

    // accepted input word: advance the model and queue its result word
    function void note_input(hrsp_pkg::in_word_t w);
      hrsp_pkg::out_word_t e;
      bit        active;
      e      = '0;
      active = st != PsDone && st != PsFailed;
      case (w.cmd)
        hrsp_pkg::CmdRestart: restart_parse();
        hrsp_pkg::CmdClose:   if (active) set_failure(hrsp_pkg::ErrClosed);
        hrsp_pkg::CmdTimeout: if (active) set_failure(hrsp_pkg::ErrTimeout);
        default: begin
          if (st == PsBody) begin
            e.payload_valid = 1'b1;
            e.payload_byte  = w.data_byte;
            body_cnt        = (body_cnt + 1) & LenMask;
            if (body_cnt >= len_val) begin
              st     = PsDone;
              e.last = 1'b1;
            end
          end else if (active) begin
            if (hdr_cnt >= max_hdr) begin
              set_failure(hrsp_pkg::ErrHdrLong);
            end else begin
              hdr_cnt++;
              if (take_header_byte(w.data_byte)) e.last = 1'b1;
            end
          end
        end
      endcase
      case (st)
        PsBody:   e.phase = hrsp_pkg::PhaseBody;
        PsDone:   e.phase = hrsp_pkg::PhaseDone;
        PsFailed: e.phase = hrsp_pkg::PhaseFailed;
        default:  e.phase = hrsp_pkg::PhaseHeaders;
      endcase
      e.error_kind  = fail_code;
      e.status_code = status;
      e.body_length = len_val[hrsp_pkg::BodyLenW-1:0];
      expected_q.push_back(e);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] seen);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    endfunction

    // accepted result word against the oldest expectation
    function void check_result(hrsp_pkg::out_word_t got);
      hrsp_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        flag("unexpected result word", '0, 64'(got.phase));
        return;
      end
      want = expected_q.pop_front();
      if (got.payload_valid !== want.payload_valid)
        flag("payload_valid", 64'(want.payload_valid), 64'(got.payload_valid));
      if (got.payload_byte !== want.payload_byte)
        flag("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
      if (got.phase !== want.phase)
        flag("phase", 64'(want.phase), 64'(got.phase));
      if (got.error_kind !== want.error_kind)
        flag("error_kind", 64'(want.error_kind), 64'(got.error_kind));
      if (got.status_code !== want.status_code)
        flag("status_code", 64'(want.status_code), 64'(got.status_code));
      if (got.body_length !== want.body_length)
        flag("body_length", 64'(want.body_length), 64'(got.body_length));
      if (got.last !== want.last)
        flag("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hrsp_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  hrsp_pkg::out_word_t out_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [11:0]         cfg_data;

  parse_scoreboard    sb = new();
  hrsp_pkg::in_word_t word_q[$];
  int                 sent_count  = 0;
  int                 burst_left  = 0;
  int                 idle_cycles = 0;
  bit                 hold_req    = 1'b0;

  http_response_stream_parser #(
    .LENGTH_BITS(LenBits)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result words are checked at the falling edge before the edge that takes them
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // watchdog on cycles with no word moving on any channel
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin : rx_stall
    int mode;
    int left;
    mode      = 0;
    left      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // word builders
  function automatic void push_data(logic [7:0] b);
    hrsp_pkg::in_word_t w;
    w.cmd       = hrsp_pkg::CmdData;
    w.data_byte = b;
    word_q.push_back(w);
  endfunction

  function automatic void push_cmd(logic [1:0] c);
    hrsp_pkg::in_word_t w;
    w.cmd       = c;
    w.data_byte = 8'($urandom_range(0, 255));
    word_q.push_back(w);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_data(s[i]);
  endfunction

  function automatic void push_decimal(logic [63:0] v, int zeros);
    string s;
    s = $sformatf("%0d", v);
    repeat (zeros) s = {"0", s};
    push_text(s);
  endfunction

  function automatic void push_eol();
    if ($urandom_range(0, 3) == 0) push_data(hrsp_pkg::ChLf);
    else push_text("\r\n");
  endfunction

  // random byte that is neither CR nor LF
  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == hrsp_pkg::ChCr || b == hrsp_pkg::ChLf) b = "x";
    return b;
  endfunction

  function automatic void push_length_name();
    string      s;
    logic [7:0] c;
    s = "content-length:";
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - hrsp_pkg::ChCaseOfs;
      push_data(c);
    end
    repeat ($urandom_range(0, 3)) push_data(hrsp_pkg::ChSpace);
  endfunction

  function automatic void push_filler(int max_len);
    string s;
    int    k;
    case ($urandom_range(0, 2))
      0: begin
        // partial name, then either a bare LF or the rest of a line
        s = "Content-Length:";
        k = $urandom_range(1, 14);
        push_text(s.substr(0, k - 1));
        if ($urandom_range(0, 1)) begin
          push_data(hrsp_pkg::ChLf);
          return;
        end
        push_data(line_byte());
      end
      1: push_text("Server: x");
      default: push_data(line_byte());
    endcase
    repeat ($urandom_range(0, max_len)) push_data(line_byte());
    push_eol();
  endfunction

  // one response: mostly well formed, some with a chosen defect
  function automatic void build_response();
    int                 kind;
    int                 start;
    int                 n_len;
    int                 body_n;
    logic [63:0]        len;
    hrsp_pkg::in_word_t w;
    kind = $urandom_range(0, 15);
    push_cmd(hrsp_pkg::CmdRestart);
    start = word_q.size();
    if (kind == 13) begin
      // noise
      repeat ($urandom_range(1, 8)) begin
        w = hrsp_pkg::in_word_t'(10'($urandom_range(0, 1023)));
        word_q.push_back(w);
      end
      return;
    end
    push_text("HTTP/1.0 ");
    if (kind == 1) word_q[start + $urandom_range(0, 8)].data_byte = 8'($urandom_range(0, 255));
    case (kind)
      2: begin
        if ($urandom_range(0, 1)) push_data(hrsp_pkg::ChSpace);
        else push_text("20x ");
      end
      3:       begin push_decimal(64'($urandom_range(0, 1500)), 0); push_data(hrsp_pkg::ChSpace); end
      default: begin
        push_decimal(64'd200, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        push_data(hrsp_pkg::ChSpace);
      end
    endcase
    repeat ($urandom_range(0, 6)) push_data(8'($urandom_range("A", "z")));
    push_eol();
    repeat ($urandom_range(0, 2)) push_filler(12);
    if (kind == 10) push_filler($urandom_range(60, 400));
    len = 64'($urandom_range(1, 24));
    if (kind == 8) len = '0;
    if (kind != 4) begin
      n_len = ($urandom_range(0, 3) == 0) ? 2 : 1;
      for (int i = 0; i < n_len; i++) begin
        push_length_name();
        if (i < n_len - 1) begin
          push_decimal(64'($urandom_range(0, 99999)), 0);
          push_eol();
        end else if (kind == 5) begin
          // malformed value: no digit, or a digit run ended by a stray byte
          if ($urandom_range(0, 1)) begin
            push_eol();
          end else begin
            push_decimal(len, 0);
            push_data($urandom_range(0, 1) ? hrsp_pkg::ChSpace : "x");
          end
        end else if (kind == 6) begin
          case ($urandom_range(0, 2))
            0:       push_decimal(LenMask, 0);
            1:       push_decimal(LenMask + 64'd1 + 64'($urandom_range(0, 9999)), 0);
            default: push_text("99999999999999999999");
          endcase
          push_eol();
        end else begin
          push_decimal(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
          push_eol();
        end
      end
    end
    if ($urandom_range(0, 2) == 0) push_filler(8);
    case ($urandom_range(0, 3))
      0:       push_data(hrsp_pkg::ChLf);
      1:       begin push_data(hrsp_pkg::ChCr); push_data(8'($urandom_range(0, 255))); end
      default: push_text("\r\n");
    endcase
    body_n = (kind == 11) ? $urandom_range(0, int'(len)) : int'(len) + $urandom_range(0, 3);
    if (kind == 6) body_n = $urandom_range(0, 10);
    repeat (body_n) push_data(8'($urandom_range(0, 255)));
    if (kind == 7 || kind == 9) begin
      // close/timeout or a corrupted byte somewhere in the response
      w = word_q[$urandom_range(start, word_q.size() - 1)];
      if (kind == 7) begin
        w.cmd = $urandom_range(0, 1) ? hrsp_pkg::CmdClose : hrsp_pkg::CmdTimeout;
        word_q.insert($urandom_range(start, word_q.size()), w);
      end else begin
        word_q[$urandom_range(start, word_q.size() - 1)].data_byte = 8'($urandom_range(0, 255));
      end
    end
    if ($urandom_range(0, 7) == 0)
      push_cmd($urandom_range(0, 1) ? hrsp_pkg::CmdClose : hrsp_pkg::CmdTimeout);
  endfunction

  // offer one word in bursts with random gaps, return once it is taken
  task automatic send_word(input hrsp_pkg::in_word_t w);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_input(w);
    sent_count++;
  endtask

  task automatic send_queued();
    while (word_q.size() != 0) send_word(word_q.pop_front());
  endtask

  // stop offering and wait for every owed result word
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_hdr_limit(input logic [11:0] v);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    sb.max_hdr = v;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [11:0] limit, input int count, input bit with_hold);
    int target;
    target = sent_count + count;
    write_hdr_limit(limit);
    while (sent_count < target) begin
      if (with_hold && sent_count > target - count / 2) begin
        hold_req  = 1'b1;
        with_hold = 1'b0;
      end
      build_response();
      send_queued();
    end
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short directed run at the reset limit
    push_data(8'h00);
    push_data(8'hFF);
    push_cmd(hrsp_pkg::CmdClose);
    push_cmd(hrsp_pkg::CmdTimeout);
    push_cmd(hrsp_pkg::CmdRestart);
    push_cmd(hrsp_pkg::CmdClose);
    push_cmd(hrsp_pkg::CmdRestart);
    push_data("H");
    push_cmd(hrsp_pkg::CmdTimeout);
    push_cmd(hrsp_pkg::CmdRestart);
    push_text("HTTP/1.0 9999 ");
    send_queued();
    drain();

    // random phases over several header limits
    run_phase(12'd16, 150, 1'b0);
    run_phase(12'd4095, 300, 1'b1);
    run_phase(12'($urandom_range(40, 200)), 250, 1'b0);
    run_phase(12'($urandom_range(0, 15)), 60, 1'b0);
    run_phase(hrsp_pkg::MaxHdrReset, 340, 1'b1);

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- http_response_stream_parser.f -----
hdl/hrsp_pkg.sv
hdl/http_response_stream_parser.sv
bench/tb_top.sv
